// ===== hdl/matrix_keypad_scan_events_core_assert.svh =====
// assertion macros for the keypad scanner core
// no dependencies; included by the top level only
`ifndef MATRIX_KEYPAD_SCAN_EVENTS_CORE_ASSERT_SVH
`define MATRIX_KEYPAD_SCAN_EVENTS_CORE_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define MKSE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define MKSE_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MKSE_ASSERT(lbl, clk, rst, prop, msg)
`define MKSE_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/mkse_pkg.sv =====
// shared types, codes and helpers for the keypad scanner core
// no dependencies
package mkse_pkg;

   localparam int KEY_BITS  = 15;
   localparam int POWER_BIT = 14;
   localparam int COL_BITS  = 6;
   localparam int IDX_BITS  = 4;

   localparam logic [15:0] POWEROFF_RESET = 16'd100;
   localparam logic [7:0]  WAKEUP_RESET   = 8'd10;
   localparam logic [7:0]  WAKE_MAX       = 8'hFF;

   // row drive per scan phase
   localparam logic [2:0] ROW_LVL_IDLE = 3'b111;
   localparam logic [2:0] ROW_EN_IDLE  = 3'b000;
   localparam logic [2:0] ROW_LVL_P0   = 3'b110;
   localparam logic [2:0] ROW_EN_P0    = 3'b001;
   localparam logic [2:0] ROW_LVL_P1   = 3'b101;
   localparam logic [2:0] ROW_EN_P1    = 3'b010;
   localparam logic [2:0] ROW_LVL_P2   = 3'b011;
   localparam logic [2:0] ROW_EN_P2    = 3'b100;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_PRESS      = 3'd1,
      EV_RELEASE    = 3'd2,
      EV_HOLD_ON    = 3'd3,
      EV_HOLD_OFF   = 3'd4,
      EV_ROTATE_ON  = 3'd5,
      EV_ROTATE_OFF = 3'd6,
      EV_POWER_OFF  = 3'd7
   } event_kind_type;

   typedef enum logic [1:0] {
      REG_HOLD_MODE      = 2'd0,
      REG_VOLUME_LOCK    = 2'd1,
      REG_POWEROFF_TICKS = 2'd2,
      REG_WAKEUP_TICKS   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_ROW0_DRIVE = 2'd0,
      PHASE_ROW0_LATCH = 2'd1,
      PHASE_ROW1_LATCH = 2'd2,
      PHASE_ROW2_LATCH = 2'd3
   } scan_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // take the item on the input and run the tick update
      logic emit;   // move the next pending event into the output register
   } mkse_cmd_type;

   typedef struct packed {
      logic pending;    // at least one event of the tick still to go
      logic slot_free;  // output register free this cycle
      logic last;       // the event selected now is the final one of the tick
   } mkse_status_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [IDX_BITS-1:0] low_index(input logic [KEY_BITS-1:0] v);
      logic [IDX_BITS-1:0] idx;
      idx = '0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/mkse_ctrl.sv =====
// controller: item acceptance and event emission sequencing
// depends on mkse_pkg
module mkse_ctrl
   import mkse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  mkse_status_type status,
   output mkse_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      in_ready = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.pending && status.slot_free) begin
               cmd.emit = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/mkse_dpath.sv =====
// datapath: scan state, key word evaluation, event queue and output register
// depends on mkse_pkg
module mkse_dpath
   import mkse_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   input  logic [7:0]      in_data,
   input  mkse_cmd_type    cmd,
   output mkse_status_type status,
   input  logic            out_ready,
   output logic            out_valid,
   output logic [2:0]      out_row_levels,
   output logic [2:0]      out_row_enable,
   output logic [2:0]      out_kind,
   output logic [3:0]      out_key_index,
   output logic [1:0]      out_leds,
   output logic            out_power,
   output logic            out_last
);

   // configuration
   logic                hold_mode_ff, volume_lock_ff;
   logic [15:0]         poweroff_ticks_ff;
   logic [7:0]          wakeup_ticks_ff;

   // scanner state
   logic [1:0]          scan_phase_ff, scan_phase_in;
   logic [COL_BITS-1:0] row0_ff, row0_in, row1_ff, row1_in, row2_ff, row2_in;
   logic [KEY_BITS-1:0] prev_keys_ff, prev_keys_in;
   logic                slide_ff, slide_in;
   logic [7:0]          wake_count_ff, wake_count_in;
   logic [15:0]         countdown_ff, countdown_in;
   logic                armed_ff, armed_in;
   logic                power_ff, power_in;
   logic [1:0]          led_ff, led_in;
   logic [2:0]          row_lvl_ff, row_lvl_in, row_en_ff, row_en_in;

   // events of the current tick
   logic                pend_off_ff, pend_off_in;
   logic                pend_rot_ff, pend_rot_in;
   logic                pend_none_ff, pend_none_in;
   logic [KEY_BITS-1:0] press_ff, press_in, release_ff, release_in;

   // output register
   logic                out_valid_ff, out_valid_in;
   logic [2:0]          o_kind_ff, o_kind_in;
   logic [3:0]          o_idx_ff, o_idx_in;
   logic [1:0]          o_led_ff;
   logic                o_power_ff, o_last_ff;
   logic [2:0]          o_lvl_ff, o_en_ff;

   // tick update terms
   logic [COL_BITS-1:0] cols, latched;
   logic                power_pin, slide_pin;
   logic                expire, scanning, evaluate, rot_on, rot_off;
   logic [KEY_BITS-1:0] cur, press, rel;

   // emission terms
   logic [IDX_BITS-1:0] p_idx, r_idx, sel_idx;
   logic [KEY_BITS-1:0] p_rest, r_rest;
   logic [1:0]          led_new;
   logic                rest_any;

   assign cols      = in_data[5:0];
   assign power_pin = in_data[6];
   assign slide_pin = in_data[7];
   assign latched   = ~cols;

   assign expire   = armed_ff && (countdown_ff <= 16'd1);
   assign scanning = wake_count_ff > wakeup_ticks_ff;
   assign evaluate = scanning && (scan_phase_ff == PHASE_ROW0_DRIVE);
   assign rot_on   = evaluate && slide_pin && !slide_ff;
   assign rot_off  = evaluate && !slide_pin && slide_ff;

   always_comb begin
      cur = {!power_pin, row2_ff[5:2], row1_ff[5:2], row0_ff};
      if (!slide_pin || volume_lock_ff) begin
         cur[1:0] = 2'b00;
      end
      press = evaluate ? (cur & ~prev_keys_ff) : '0;
      rel   = evaluate ? (prev_keys_ff & ~cur) : '0;
   end

   // event selection: power off, then rotate, then presses, then releases
   assign p_idx  = low_index(press_ff);
   assign r_idx  = low_index(release_ff);
   assign p_rest = press_ff & (press_ff - KEY_BITS'(1));
   assign r_rest = release_ff & (release_ff - KEY_BITS'(1));

   always_comb begin
      o_kind_in = EV_NONE;
      sel_idx   = '0;
      led_new   = led_ff;
      rest_any  = 1'b0;
      priority if (pend_off_ff) begin
         o_kind_in = EV_POWER_OFF;
         rest_any  = pend_rot_ff || (|press_ff) || (|release_ff);
      end else if (pend_rot_ff) begin
         if (slide_ff) begin
            o_kind_in = EV_ROTATE_ON;
         end else begin
            o_kind_in = EV_ROTATE_OFF;
            led_new   = 2'b00;
         end
         rest_any = (|press_ff) || (|release_ff);
      end else if (|press_ff) begin
         sel_idx = p_idx;
         if (hold_mode_ff && p_idx != IDX_BITS'(POWER_BIT)) begin
            o_kind_in = EV_HOLD_ON;
         end else begin
            o_kind_in = EV_PRESS;
            if (!hold_mode_ff && slide_ff && p_idx < IDX_BITS'(2)) begin
               led_new[p_idx[0]] = 1'b1;
            end
         end
         rest_any = (|p_rest) || (|release_ff);
      end else if (|release_ff) begin
         sel_idx = r_idx;
         if (hold_mode_ff && r_idx != IDX_BITS'(POWER_BIT)) begin
            o_kind_in = EV_HOLD_OFF;
         end else begin
            o_kind_in = EV_RELEASE;
            if (!hold_mode_ff && slide_ff && r_idx < IDX_BITS'(2)) begin
               led_new[r_idx[0]] = 1'b0;
            end
         end
         rest_any = |r_rest;
      end
      o_idx_in = sel_idx;
   end

   assign status.pending   = pend_off_ff || pend_rot_ff || pend_none_ff ||
                             (|press_ff) || (|release_ff);
   assign status.slot_free = !out_valid_ff || out_ready;
   assign status.last      = !rest_any;

   // next state
   always_comb begin
      scan_phase_in = scan_phase_ff;
      row0_in       = row0_ff;
      row1_in       = row1_ff;
      row2_in       = row2_ff;
      prev_keys_in  = prev_keys_ff;
      slide_in      = slide_ff;
      wake_count_in = wake_count_ff;
      countdown_in  = countdown_ff;
      armed_in      = armed_ff;
      power_in      = power_ff;
      led_in        = led_ff;
      row_lvl_in    = row_lvl_ff;
      row_en_in     = row_en_ff;
      pend_off_in   = pend_off_ff;
      pend_rot_in   = pend_rot_ff;
      pend_none_in  = pend_none_ff;
      press_in      = press_ff;
      release_in    = release_ff;
      out_valid_in  = out_valid_ff && !out_ready;

      if (cmd.load) begin
         // countdown runs before the scan
         if (armed_ff) begin
            if (expire) begin
               countdown_in = '0;
               armed_in     = 1'b0;
               power_in     = 1'b0;
            end else begin
               countdown_in = countdown_ff - 16'd1;
            end
         end
         if (scanning) begin
            unique case (scan_phase_ff)
               PHASE_ROW0_DRIVE: begin
                  row_lvl_in = ROW_LVL_P0;
                  row_en_in  = ROW_EN_P0;
               end
               PHASE_ROW0_LATCH: begin
                  row0_in    = latched;
                  row_lvl_in = ROW_LVL_P1;
                  row_en_in  = ROW_EN_P1;
               end
               PHASE_ROW1_LATCH: begin
                  row1_in    = latched;
                  row_lvl_in = ROW_LVL_P2;
                  row_en_in  = ROW_EN_P2;
               end
               default: begin
                  row2_in    = latched;
                  row_lvl_in = ROW_LVL_IDLE;
                  row_en_in  = ROW_EN_IDLE;
               end
            endcase
            scan_phase_in = scan_phase_ff + 2'd1;
         end else if (wake_count_ff != WAKE_MAX) begin
            wake_count_in = wake_count_ff + 8'd1;
         end
         if (evaluate) begin
            slide_in     = slide_pin;
            prev_keys_in = cur;
            if (press[POWER_BIT]) begin
               countdown_in = poweroff_ticks_ff;
               armed_in     = 1'b1;
            end
            if (rel[POWER_BIT]) begin
               countdown_in = '0;
               armed_in     = 1'b0;
            end
         end
         pend_off_in  = expire;
         pend_rot_in  = rot_on || rot_off;
         press_in     = press;
         release_in   = rel;
         pend_none_in = !(expire || rot_on || rot_off || (|press) || (|rel));
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         led_in       = led_new;
         pend_none_in = 1'b0;
         priority if (pend_off_ff) begin
            pend_off_in = 1'b0;
         end else if (pend_rot_ff) begin
            pend_rot_in = 1'b0;
         end else if (|press_ff) begin
            press_in = p_rest;
         end else begin
            release_in = r_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mode_ff      <= 1'b0;
         volume_lock_ff    <= 1'b0;
         poweroff_ticks_ff <= POWEROFF_RESET;
         wakeup_ticks_ff   <= WAKEUP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_HOLD_MODE:      hold_mode_ff      <= csr_wdata[0];
            REG_VOLUME_LOCK:    volume_lock_ff    <= csr_wdata[0];
            REG_POWEROFF_TICKS: poweroff_ticks_ff <= csr_wdata;
            default:            wakeup_ticks_ff   <= csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_phase_ff <= PHASE_ROW0_DRIVE;
         row0_ff       <= '0;
         row1_ff       <= '0;
         row2_ff       <= '0;
         prev_keys_ff  <= '0;
         slide_ff      <= 1'b0;
         wake_count_ff <= '0;
         countdown_ff  <= '0;
         armed_ff      <= 1'b0;
         power_ff      <= 1'b1;
         led_ff        <= '0;
         row_lvl_ff    <= ROW_LVL_IDLE;
         row_en_ff     <= ROW_EN_IDLE;
         pend_off_ff   <= 1'b0;
         pend_rot_ff   <= 1'b0;
         pend_none_ff  <= 1'b0;
         press_ff      <= '0;
         release_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         scan_phase_ff <= scan_phase_in;
         row0_ff       <= row0_in;
         row1_ff       <= row1_in;
         row2_ff       <= row2_in;
         prev_keys_ff  <= prev_keys_in;
         slide_ff      <= slide_in;
         wake_count_ff <= wake_count_in;
         countdown_ff  <= countdown_in;
         armed_ff      <= armed_in;
         power_ff      <= power_in;
         led_ff        <= led_in;
         row_lvl_ff    <= row_lvl_in;
         row_en_ff     <= row_en_in;
         pend_off_ff   <= pend_off_in;
         pend_rot_ff   <= pend_rot_in;
         pend_none_ff  <= pend_none_in;
         press_ff      <= press_in;
         release_ff    <= release_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // result payload, loaded on emit only
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_kind_ff  <= o_kind_in;
         o_idx_ff   <= o_idx_in;
         o_led_ff   <= led_new;
         o_power_ff <= power_ff;
         o_last_ff  <= !rest_any;
         o_lvl_ff   <= row_lvl_ff;
         o_en_ff    <= row_en_ff;
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_row_levels = o_lvl_ff;
   assign out_row_enable = o_en_ff;
   assign out_kind       = o_kind_ff;
   assign out_key_index  = o_idx_ff;
   assign out_leds       = o_led_ff;
   assign out_power      = o_power_ff;
   assign out_last       = o_last_ff;

endmodule

// ===== hdl/matrix_keypad_scan_events_core.sv =====
// Keypad scanner core. One input item is one scan tick carrying the column
// pins, the power pin and the slide pin; it yields between one and seventeen
// result items, the final one marked by rsp_tlast. An item is taken while the
// controller is idle, and its results then leave one a cycle through the
// output register while the consumer keeps rsp_tready high; the event
// emitter hands out one event per cycle whenever the output register is free.
// req_tready is high only between ticks, while the previous tick's final
// result may still sit in the output register. Configuration is to be
// written through csr_* between ticks only; the block does not enforce this.
// Depends on mkse_pkg, mkse_ctrl, mkse_dpath and the assertion header.
`include "matrix_keypad_scan_events_core_assert.svh"

module matrix_keypad_scan_events_core
   import mkse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // scan tick items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // column_pins[5:0], power_pin[6], slide_pin[7]
   // event items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // row_levels[2:0], row_drive_enable[5:3],
                                    // key_index[9:6], led_zero[10], led_one[11],
                                    // power_on[12], zero[15:13]
   output logic [2:0]  rsp_tuser,   // event_kind[2:0]
   output logic        rsp_tlast    // final event of the tick
);

   mkse_cmd_type    cmd;
   mkse_status_type status;

   logic [2:0] row_levels, row_enable, kind;
   logic [3:0] key_index;
   logic [1:0] leds;
   logic       power_on, last;

   // sequencing: idle until a tick arrives, then emit its events
   mkse_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // scan state, key word compare, pending events and output register
   mkse_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_data        (req_tdata),
      .cmd            (cmd),
      .status         (status),
      .out_ready      (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_row_levels (row_levels),
      .out_row_enable (row_enable),
      .out_kind       (kind),
      .out_key_index  (key_index),
      .out_leds       (leds),
      .out_power      (power_on),
      .out_last       (last)
   );

   // pack the result fields, lowest field in the lowest bits
   assign rsp_tdata = {3'b000, power_on, leds[1], leds[0], key_index, row_enable, row_levels};
   assign rsp_tuser = kind;
   assign rsp_tlast = last;

   // a new tick is only taken once every event of the last one has moved into the output register
   `MKSE_ASSERT(a_ready_when_drained, clock, reset, req_tready |-> !status.pending,
      "tick accepted with events still pending")
   // an item with no event is always the only, hence final, item of its tick
   `MKSE_ASSERT(a_none_is_last, clock, reset,
      (rsp_tvalid && rsp_tuser == EV_NONE) |-> rsp_tlast,
      "empty tick result not marked last")
   // power control never comes back once dropped
   `MKSE_ASSERT(a_power_stays_off, clock, reset,
      (rsp_tvalid && !rsp_tdata[12]) |=> !(rsp_tvalid && rsp_tdata[12]),
      "power_on raised again after power off")
   // emission only happens while the controller is working on a tick
   `MKSE_NEVER(a_no_emit_when_idle, clock, reset, cmd.emit && req_tready,
      "event emitted while idle")

endmodule

// ===== dv/tb_matrix_keypad_scan_events_core.sv =====
// self-checking testbench for matrix_keypad_scan_events_core: scan ticks in, key events out
// predicts every event of every tick and compares field by field
// depends on mkse_pkg and the core rtl only

module tb_matrix_keypad_scan_events_core;
   import mkse_pkg::*;

   // one expected event item
   typedef struct {
      logic [2:0]     row_lvl;
      logic [2:0]     row_en;
      event_kind_type kind;
      logic [3:0]     key;
      logic           led0;
      logic           led1;
      logic           pwr;
      logic           last;
   } key_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_HOLD_MODE;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // column_pins[5:0], power_pin[6], slide_pin[7]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // row_levels[2:0], row_drive_enable[5:3], key_index[9:6],
                                 // led_zero[10], led_one[11], power_on[12], zero[15:13]
   logic [2:0]  rsp_tuser;       // event_kind[2:0]
   logic        rsp_tlast;

   matrix_keypad_scan_events_core uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // scanner state as seen by the predictor
   // ---------------------------------------------------------------
   logic           cfg_hold     = 1'b0;
   logic           cfg_vlock    = 1'b0;
   logic [15:0]    cfg_poweroff = POWEROFF_RESET;
   logic [7:0]     cfg_wakeup   = WAKEUP_RESET;

   scan_phase_type scan_ph   = PHASE_ROW0_DRIVE;
   logic [5:0]     row0_bits = '0;
   logic [5:0]     row1_bits = '0;
   logic [5:0]     row2_bits = '0;
   logic [14:0]    prev_keys = '0;
   logic           slide_st  = 1'b0;
   logic [7:0]     wake_cnt  = '0;
   logic [15:0]    cdown     = '0;
   logic           cd_armed  = 1'b0;
   logic           pwr_st    = 1'b1;
   logic [1:0]     leds      = '0;
   logic [2:0]     row_lvl   = ROW_LVL_IDLE;
   logic [2:0]     row_en    = ROW_EN_IDLE;

   key_event_type  pending_events[$];   // events still owed by the core, oldest first
   logic [7:0]     tick_queue[$];       // scan ticks not yet handed to the core by the driver
   int             errors      = 0;
   int             event_count = 0;
   int             gap_left    = 0;
   int             stall_left  = 0;
   bit             idle_on     = 1'b0;

   // stimulus view of the keyboard: pressed bits per row, power held, slide open
   logic [5:0]     gen_rows[3] = '{6'h00, 6'h00, 6'h00};
   logic           gen_power   = 1'b0;
   logic           gen_slide   = 1'b0;
   logic [7:0]     gen_wake    = '0;
   scan_phase_type gen_phase   = PHASE_ROW0_DRIVE;

   // settings of the random phases, extremes included
   logic        hold_set[8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
   logic        lock_set[8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
   logic [15:0] po_set[8]   = '{16'd20, 16'd1, 16'd65535, 16'd7, 16'd50, 16'd0, 16'd12,
                                16'd30};
   logic [7:0]  wk_set[8]   = '{8'd0, 8'd3, 8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd5};

   // event carrying the led and power state at the moment it is raised
   function automatic key_event_type make_event(input event_kind_type k, input int idx);
      key_event_type ev;
      ev.row_lvl = '0;
      ev.row_en  = '0;
      ev.kind    = k;
      ev.key     = 4'(idx);
      ev.led0    = leds[0];
      ev.led1    = leds[1];
      ev.pwr     = pwr_st;
      ev.last    = 1'b0;
      return ev;
   endfunction

   // advance the scanner by one accepted tick and queue the events it owes
   task automatic scan_tick(input logic [7:0] item);
      key_event_type evs[$];
      logic [5:0]    latched;
      logic [14:0]   cur;
      logic [14:0]   press_bits;
      logic [14:0]   rel_bits;
      latched = ~item[5:0];

      // power-off countdown runs ahead of the scan
      if (cd_armed) begin
         if (cdown <= 16'd1) begin
            cdown    = '0;
            cd_armed = 1'b0;
            pwr_st   = 1'b0;
            evs.push_back(make_event(EV_POWER_OFF, 0));
         end else begin
            cdown--;
         end
      end

      if (wake_cnt > cfg_wakeup) begin
         case (scan_ph)
            PHASE_ROW0_DRIVE: begin
               row_lvl = ROW_LVL_P0;
               row_en  = ROW_EN_P0;
               cur = {~item[6], row2_bits[5:2], row1_bits[5:2], row0_bits};
               if (item[7]) begin
                  if (!slide_st) begin
                     slide_st = 1'b1;
                     evs.push_back(make_event(EV_ROTATE_ON, 0));
                  end
                  if (cfg_vlock) cur[1:0] = 2'b00;
               end else begin
                  if (slide_st) begin
                     slide_st = 1'b0;
                     leds     = 2'b00;
                     evs.push_back(make_event(EV_ROTATE_OFF, 0));
                  end
                  cur[1:0] = 2'b00;
               end
               press_bits = cur & ~prev_keys;
               rel_bits   = prev_keys & ~cur;
               // presses first, then releases, lowest index first
               for (int i = 0; i < KEY_BITS; i++) begin
                  if (press_bits[i]) begin
                     if (i == POWER_BIT) begin
                        cdown    = cfg_poweroff;
                        cd_armed = 1'b1;
                     end
                     if (cfg_hold && i != POWER_BIT) begin
                        evs.push_back(make_event(EV_HOLD_ON, i));
                     end else begin
                        if (!cfg_hold && slide_st && i < 2) leds[i] = 1'b1;
                        evs.push_back(make_event(EV_PRESS, i));
                     end
                  end
               end
               for (int i = 0; i < KEY_BITS; i++) begin
                  if (rel_bits[i]) begin
                     if (i == POWER_BIT) begin
                        cdown    = '0;
                        cd_armed = 1'b0;
                     end
                     if (cfg_hold && i != POWER_BIT) begin
                        evs.push_back(make_event(EV_HOLD_OFF, i));
                     end else begin
                        if (!cfg_hold && slide_st && i < 2) leds[i] = 1'b0;
                        evs.push_back(make_event(EV_RELEASE, i));
                     end
                  end
               end
               prev_keys = cur;
            end
            PHASE_ROW0_LATCH: begin
               row0_bits = latched;
               row_lvl   = ROW_LVL_P1;
               row_en    = ROW_EN_P1;
            end
            PHASE_ROW1_LATCH: begin
               row1_bits = latched;
               row_lvl   = ROW_LVL_P2;
               row_en    = ROW_EN_P2;
            end
            default: begin
               row2_bits = latched;
               row_lvl   = ROW_LVL_IDLE;
               row_en    = ROW_EN_IDLE;
            end
         endcase
         scan_ph = scan_phase_type'(scan_ph + 2'd1);
      end else if (wake_cnt != WAKE_MAX) begin
         wake_cnt++;
      end

      // a quiet tick still reports rows, leds and power
      if (evs.size() == 0) evs.push_back(make_event(EV_NONE, 0));
      foreach (evs[k]) begin
         evs[k].row_lvl = row_lvl;
         evs[k].row_en  = row_en;
         evs[k].last    = (k == evs.size() - 1);
         pending_events.push_back(evs[k]);
      end
   endtask

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic flag_error(input string msg);
      errors++;
      $display("error at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_error($sformatf("event %0d %s: got %0d, expected %0d",
                              event_count, name, got, want));
   endtask

   // mostly short idles, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ---------------------------------------------------------------
   // driver: hands scan ticks to the core, predicts on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) scan_tick(req_tdata);
         // the slot is free when nothing is offered or the offer was just taken
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               req_tdata  <= tick_queue.pop_front();
               req_tvalid <= 1'b1;
               gap_left = idle_on ? idle_len() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: takes event items with random back-pressure
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      key_event_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               flag_error($sformatf("event item kind %0d with nothing expected", rsp_tuser));
            end else begin
               want = pending_events.pop_front();
               check_field("row_levels", rsp_tdata[2:0], want.row_lvl);
               check_field("row_drive_enable", rsp_tdata[5:3], want.row_en);
               check_field("event_kind", rsp_tuser, want.kind);
               check_field("key_index", rsp_tdata[9:6], want.key);
               check_field("led_zero", rsp_tdata[10], want.led0);
               check_field("led_one", rsp_tdata[11], want.led1);
               check_field("power_on", rsp_tdata[12], want.pwr);
               check_field("pad bits", rsp_tdata[15:13], 0);
               check_field("last", rsp_tlast, want.last);
            end
            event_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = (idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   // sampled away from the active edge so that pending updates have settled
   task automatic wait_idle();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_tvalid || pending_events.size() != 0);
   endtask

   task automatic cfg_write(input csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_HOLD_MODE:      cfg_hold     = val[0];
         REG_VOLUME_LOCK:    cfg_vlock    = val[0];
         REG_POWEROFF_TICKS: cfg_poweroff = val;
         default:            cfg_wakeup   = val[7:0];
      endcase
   endtask

   // registers only change with the core drained
   task automatic apply_settings(input logic h, input logic v, input logic [15:0] po,
                                 input logic [7:0] wk);
      wait_idle();
      cfg_write(REG_HOLD_MODE, 16'(h));
      cfg_write(REG_VOLUME_LOCK, 16'(v));
      cfg_write(REG_POWEROFF_TICKS, po);
      cfg_write(REG_WAKEUP_TICKS, 16'(wk));
      @(posedge clock);
      csr_we <= 1'b0;
      gen_wake  = wake_cnt;
      gen_phase = scan_ph;
   endtask

   // ticks that present the current keyboard on the row being latched;
   // the percentage of ticks replaced by random pins is the noise
   task automatic queue_ticks(input int n, input int noise_pct);
      logic [7:0] item;
      for (int k = 0; k < n; k++) begin
         item = {gen_slide, ~gen_power, 6'($urandom)};
         if (gen_wake > cfg_wakeup) begin
            case (gen_phase)
               PHASE_ROW0_LATCH: item[5:0] = ~gen_rows[0];
               PHASE_ROW1_LATCH: item[5:0] = ~gen_rows[1];
               PHASE_ROW2_LATCH: item[5:0] = ~gen_rows[2];
               default: ;
            endcase
            gen_phase = scan_phase_type'(gen_phase + 2'd1);
         end else if (gen_wake != WAKE_MAX) begin
            gen_wake++;
         end
         if ($urandom_range(0, 99) < noise_pct) item = 8'($urandom);
         tick_queue.push_back(item);
      end
   endtask

   // one full scan of a fixed keyboard, evaluated on its closing tick
   task automatic queue_scan(input logic [5:0] r0, input logic [5:0] r1, input logic [5:0] r2,
                             input logic pwr, input logic sld);
      gen_rows[0] = r0;
      gen_rows[1] = r1;
      gen_rows[2] = r2;
      gen_power   = pwr;
      gen_slide   = sld;
      queue_ticks(4, 0);
   endtask

   // small changes to the keyboard between scans, now and then all keys at once
   task automatic shuffle_keys();
      int b;
      case ($urandom_range(0, 9))
         0: gen_rows = '{6'h00, 6'h00, 6'h00};
         1: gen_rows = '{6'h3F, 6'h3F, 6'h3F};
         default: begin
            repeat ($urandom_range(1, 3)) begin
               b = $urandom_range(0, 18);
               if (b == 18) gen_power = !gen_power;
               else gen_rows[b / 6][b % 6] = !gen_rows[b / 6][b % 6];
            end
         end
      endcase
      if ($urandom_range(0, 99) < 15) gen_slide = !gen_slide;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wake-up delay under the reset register values, pins fully random
      idle_on = 1'b1;
      queue_ticks(14, 100);

      // directed: short countdown, scanning at once, line up on the row 0 latch tick
      apply_settings(1'b0, 1'b0, 16'd4, 8'd0);
      while (gen_phase != PHASE_ROW0_LATCH) queue_ticks(1, 0);
      // everything released
      queue_scan(6'h00, 6'h00, 6'h00, 1'b0, 1'b0);
      // power key alone arms the countdown
      queue_scan(6'h00, 6'h00, 6'h00, 1'b1, 1'b0);
      // countdown runs out on the same tick as slide open, every key pressed
      // and power released: the longest burst of events
      queue_scan(6'h3F, 6'h3F, 6'h3F, 1'b0, 1'b1);
      // slide closing drops the leds and masks the volume keys; power again
      queue_scan(6'h3F, 6'h3F, 6'h3F, 1'b1, 1'b0);
      // second long press powers off again while the keys come up
      queue_scan(6'h00, 6'h00, 6'h00, 1'b1, 1'b0);
      // volume keys alone with the slide open light their leds
      queue_scan(6'h03, 6'h00, 6'h00, 1'b0, 1'b1);

      // random phases, one setting each, some without any idling
      for (int p = 0; p < 8; p++) begin
         apply_settings(hold_set[p], lock_set[p], po_set[p], wk_set[p]);
         idle_on = (p % 3 != 1);
         for (int k = 0; k < ((wk_set[p] == WAKE_MAX) ? 10 : 25); k += 4) begin
            shuffle_keys();
            queue_ticks(4, 8);
         end
      end

      wait_idle();
      // room for any stray event item to show up
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("** matrix_keypad_scan_events_core: PASSED **");
      end else begin
         $display("** matrix_keypad_scan_events_core: FAILED **");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("** matrix_keypad_scan_events_core: FAILED **");
      $finish;
   end

endmodule
